// File: design/assert_macros.svh
// Assertion macros shared by the RTL. Simulation builds get the checks,
// synthesis builds get empty bodies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Same-cycle implication, sampled on the rising clock edge outside reset.
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("assertion failed: same-cycle implication");

// Next-cycle implication, sampled on the rising clock edge outside reset.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("assertion failed: next-cycle implication");

`else

`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons)
`define ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

// File: design/iiea_pkg.sv
`default_nettype none

package iiea_pkg;

    // List geometry.
    localparam int DEPTH   = 64;
    localparam int IDX_W   = $clog2(DEPTH);
    localparam int CNT_W   = $clog2(DEPTH + 1);

    // Fixed field widths of the request and result.
    localparam int KIND_W  = 3;
    localparam int POS_W   = 7;
    localparam int WORD_W  = 32;
    localparam int COUNT_W = 7;

    // Width used to compare a position against the fill count.
    localparam int CMP_W   = (POS_W > CNT_W) ? POS_W : CNT_W;

    // Request codes.
    typedef enum logic [KIND_W-1:0] {
        REQ_APPEND = 3'd0,
        REQ_POP    = 3'd1,
        REQ_INSERT = 3'd2,
        REQ_ERASE  = 3'd3,
        REQ_READ   = 3'd4,
        REQ_CLEAR  = 3'd5
    } t_req_kind;

    // Status codes.
    typedef enum logic [1:0] {
        ST_DONE = 2'd0,
        ST_BAD  = 2'd1,
        ST_FULL = 2'd2
    } t_status;

    // One request as held in the input register.
    typedef struct packed {
        logic [KIND_W-1:0]        kind;
        logic [POS_W-1:0]         position;
        logic signed [WORD_W-1:0] word;
    } t_request;

    // One result as produced by the list cells.
    typedef struct packed {
        logic signed [WORD_W-1:0] read_word;
        t_status                  status;
        logic [CNT_W-1:0]         count;
    } t_result;

endpackage

`default_nettype wire

// File: design/iiea_cells.sv
`default_nettype none

module iiea_cells
    import iiea_pkg::*;
(
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire logic     i_en,
    input  wire t_request i_req,
    output t_result       o_res
);

    logic signed [WORD_W-1:0] r_cells [DEPTH];
    logic signed [WORD_W-1:0] n_cells [DEPTH];
    logic [CNT_W-1:0]         r_count;
    logic [CNT_W-1:0]         n_count;

    logic [CMP_W-1:0] ext_pos;
    logic [CMP_W-1:0] ext_cnt;
    logic             is_full;
    logic             do_append;
    logic             do_insert;
    logic             do_erase;

    assign ext_pos = CMP_W'(i_req.position);
    assign ext_cnt = CMP_W'(r_count);
    assign is_full = (r_count == CNT_W'(DEPTH));

    // Decode the request against the current fill count.
    always_comb begin
        n_count         = r_count;
        o_res.read_word = '0;
        o_res.status    = ST_DONE;
        do_append       = 1'b0;
        do_insert       = 1'b0;
        do_erase        = 1'b0;
        case (i_req.kind)
            REQ_APPEND: begin
                if (is_full) begin
                    o_res.status = ST_FULL;
                end else begin
                    do_append = 1'b1;
                    n_count   = r_count + 1'b1;
                end
            end
            REQ_POP: begin
                if (r_count == '0) begin
                    o_res.status = ST_BAD;
                end else begin
                    n_count = r_count - 1'b1;
                end
            end
            REQ_INSERT: begin
                if (ext_pos > ext_cnt) begin
                    o_res.status = ST_BAD;
                end else if (is_full) begin
                    o_res.status = ST_FULL;
                end else begin
                    do_insert = 1'b1;
                    n_count   = r_count + 1'b1;
                end
            end
            REQ_ERASE: begin
                if (ext_pos >= ext_cnt) begin
                    o_res.status = ST_BAD;
                end else begin
                    do_erase = 1'b1;
                    n_count  = r_count - 1'b1;
                end
            end
            REQ_READ: begin
                if (ext_pos >= ext_cnt) begin
                    o_res.status    = ST_BAD;
                    o_res.read_word = '1;
                end else begin
                    o_res.read_word = r_cells[ext_pos[IDX_W-1:0]];
                end
            end
            REQ_CLEAR: begin
                n_count = '0;
            end
            default: begin
                o_res.status = ST_BAD;
            end
        endcase
        o_res.count = n_count;
    end

    // Each cell picks its next word from itself, a neighbour or the new word.
    always_comb begin
        for (int k = 0; k < DEPTH; k++) begin
            n_cells[k] = r_cells[k];
            if (do_append && (CMP_W'(k) == ext_cnt)) begin
                n_cells[k] = i_req.word;
            end else if (do_insert && (CMP_W'(k) > ext_pos)) begin
                n_cells[k] = r_cells[(k == 0) ? 0 : k - 1];
            end else if (do_insert && (CMP_W'(k) == ext_pos)) begin
                n_cells[k] = i_req.word;
            end else if (do_erase && (CMP_W'(k) >= ext_pos) && (k < DEPTH - 1)) begin
                n_cells[k] = r_cells[(k == DEPTH - 1) ? k : k + 1];
            end
        end
    end

    // Stored words carry no reset; only entries below the count are read.
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_cells <= n_cells;
        end
    end

    // Fill count.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else if (i_en) begin
            r_count <= n_count;
        end
    end

endmodule

`default_nettype wire

// File: design/indexed_insert_erase_array_core.sv
// Ordered list of up to 64 signed 32-bit words, held in a row of registers.
// Input channel: i_valid with o_stall; a transaction carries a request code,
// a position and a word. Output channel: o_valid with i_stall; a transaction
// carries the read word, a status, the count after the request and an empty
// flag. Every request gives exactly one result, in request order.
// A request is captured in an input register at the edge that accepts it.
// It is applied to the list (all cells shift in parallel), and its result
// captured in the output register, at the first edge where that register
// can take it. One request per cycle is sustained while the receiver does
// not stall; the rate is set by the single pass between the two registers.
// When the receiver stalls, the result is held and the request behind it
// waits in the input register; o_stall rises only when both are occupied.
// Reset empties the list (count zero) and drops anything in flight; the
// stored words themselves are not cleared and no clearing pass is needed.
`default_nettype none

`include "assert_macros.svh"

module indexed_insert_erase_array_core
    import iiea_pkg::*;
(
    input  wire logic                     i_clk,
    input  wire logic                     i_rst_n,
    input  wire logic                     i_valid,
    output logic                          o_stall,
    input  wire logic [KIND_W-1:0]        i_req_type,
    input  wire logic [POS_W-1:0]         i_position,
    input  wire logic signed [WORD_W-1:0] i_word_in,
    output logic                          o_valid,
    input  wire logic                     i_stall,
    output logic signed [WORD_W-1:0]      o_read_word,
    output logic [1:0]                    o_status,
    output logic [COUNT_W-1:0]            o_count,
    output logic                          o_is_empty
);

    logic     r_req_valid;
    t_request r_req;
    logic     r_out_valid;
    t_result  r_res;
    t_result  cell_res;
    logic     advance;
    logic     apply;
    logic     accept;

    // The output register can take a new result when empty or being drained.
    assign advance = !r_out_valid || !i_stall;
    assign apply   = r_req_valid && advance;
    assign o_stall = r_req_valid && !advance;
    assign accept  = i_valid && !o_stall;

    // Input register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_req_valid <= 1'b0;
        end else if (accept || apply) begin
            r_req_valid <= accept;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_req.kind     <= i_req_type;
            r_req.position <= i_position;
            r_req.word     <= i_word_in;
        end
    end

    // List cells and fill count.
    iiea_cells u_cells (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (apply),
        .i_req   (r_req),
        .o_res   (cell_res)
    );

    // Output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= r_req_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (apply) begin
            r_res <= cell_res;
        end
    end

    assign o_valid     = r_out_valid;
    assign o_read_word = r_res.read_word;
    assign o_status    = r_res.status;
    assign o_count     = COUNT_W'(r_res.count);
    assign o_is_empty  = (r_res.count == '0);

    // A full drop can only be reported with the list at capacity.
    `ASSERT_IMPLIES(a_full_at_depth, i_clk, i_rst_n, r_out_valid && (r_res.status == ST_FULL), r_res.count == CNT_W'(DEPTH))
    // The count never exceeds the depth.
    `ASSERT_IMPLIES(a_count_bound, i_clk, i_rst_n, r_out_valid, r_res.count <= CNT_W'(DEPTH))
    // A request applied to the list shows up as a result at the next edge.
    `ASSERT_NEXT(a_apply_to_out, i_clk, i_rst_n, apply, r_out_valid)
    // A refused input means both the input and output registers are occupied.
    `ASSERT_IMPLIES(a_stall_cause, i_clk, i_rst_n, o_stall, r_req_valid && r_out_valid && i_stall)

endmodule

`default_nettype wire
